>>> src/apfp_pkg.sv
package apfp_pkg;

    // frame layout
    localparam int          CNT_W        = 17;
    localparam logic [7:0]  EXT_MARKER   = 8'h00;
    localparam int          HDR_LEN      = 4;
    localparam int          SHORT_HDR    = 5;
    localparam int          SHORT_LE     = 6;
    localparam int          EXT_HDR      = 7;
    localparam int          EXT_LE       = 9;
    localparam logic [16:0] COUNT_MAX    = 17'h1FFFF;
    localparam logic [16:0] MAX_FRAME_RST = 17'd1024;

    // output queue
    localparam int          FIFO_DEPTH   = 4;

    // result kinds
    localparam logic        KIND_PAYLOAD = 1'b0;
    localparam logic        KIND_VERDICT = 1'b1;

    // verdict codes
    localparam logic [1:0]  STATUS_OK       = 2'd0;
    localparam logic [1:0]  STATUS_MISMATCH = 2'd1;
    localparam logic [1:0]  STATUS_RANGE    = 2'd2;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  class_byte;
        logic [7:0]  instruction_byte;
        logic [7:0]  param_one;
        logic [7:0]  param_two;
        logic [15:0] payload_length;
        logic [1:0]  frame_status;
        logic        run_last;
    } t_out_item;

    // queue write request: up to two results per input byte
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  slot1;
        t_out_item  slot0;
    } t_push_req;

endpackage

>>> src/apfp_out_fifo.sv
module apfp_out_fifo #(
    parameter int DEPTH = apfp_pkg::FIFO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  apfp_pkg::t_push_req  i_push,
    output logic                 o_room_two,
    output logic                 o_valid,
    input  logic                 i_stall,
    output apfp_pkg::t_out_item  o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    apfp_pkg::t_out_item r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic [AW-1:0] wr_ptr_nx;
    logic          pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
        return r;
    endfunction

    assign o_valid    = (r_count != '0);
    assign o_room_two = (r_count <= CW'(DEPTH - 2));
    assign o_data     = r_mem[r_rd_ptr];
    assign pop        = o_valid && !i_stall;
    assign wr_ptr_nx  = ptr_inc(r_wr_ptr);

    always_comb begin
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        unique case (i_push.cnt)
            2'd1:    n_wr_ptr = wr_ptr_nx;
            2'd2:    n_wr_ptr = ptr_inc(wr_ptr_nx);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_count = r_count + CW'(i_push.cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.slot0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_nx] <= i_push.slot1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("output queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room_two)
        else $error("push without two free slots");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not drain the queue");

endmodule

>>> src/apdu_frame_parser.sv
// Each result is registered in the output queue when its byte is accepted.
// Throughput: one frame byte per cycle while the queue has two free slots; a final
//   byte that is also payload makes two results, which leave one per unstalled cycle.
// Input stall follows the fill of the output queue (needs two free slots).
// Reset (i_rst_n, synchronous, active low) clears frame state, empties the queue and
//   loads max_frame_bytes with 1024.
module apdu_frame_parser #(
    parameter int P_FIFO_DEPTH = apfp_pkg::FIFO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte stream in
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  apfp_pkg::t_in_item   i_in_data,
    // results out
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output apfp_pkg::t_out_item  o_out_data,
    // max_frame_bytes register
    input  logic                 i_cfg_we,
    input  logic [16:0]          i_cfg_data
);

    // 18-bit forms of the frame offsets; total length can reach 0x20000
    localparam logic [17:0] L_HDR       = 18'(apfp_pkg::HDR_LEN);
    localparam logic [17:0] L_SHORT_HDR = 18'(apfp_pkg::SHORT_HDR);
    localparam logic [17:0] L_SHORT_LE  = 18'(apfp_pkg::SHORT_LE);
    localparam logic [17:0] L_EXT_HDR   = 18'(apfp_pkg::EXT_HDR);
    localparam logic [17:0] L_EXT_LE    = 18'(apfp_pkg::EXT_LE);

    // frame state
    logic [16:0] r_max_frame;
    logic [16:0] r_byte_count, n_byte_count;
    logic [31:0] r_header,     n_header;
    logic [7:0]  r_marker,     n_marker;
    logic [7:0]  r_ext_high,   n_ext_high;
    logic [15:0] r_decl,       n_decl;

    logic        in_acc;
    logic        room_two;
    logic [7:0]  b;
    logic        last;
    logic [17:0] p;          // position of this byte in the frame
    logic [17:0] total;      // frame length including this byte
    logic [17:0] start;      // first payload position
    logic [17:0] pay_end;
    logic [17:0] len_v;
    logic        ext_cur;
    logic        ext_v;
    logic        is_pay;
    logic        emit_pay;
    logic [1:0]  status;

    apfp_pkg::t_out_item pay_item;
    apfp_pkg::t_out_item verdict_item;
    apfp_pkg::t_push_req push;

    assign b          = i_in_data.frame_byte;
    assign last       = i_in_data.frame_end;
    assign o_in_stall = !room_two;
    assign in_acc     = i_in_valid && room_two;

    // byte decode: header capture, length field, payload window
    always_comb begin
        p          = {1'b0, r_byte_count};
        total      = p + 18'd1;
        ext_cur    = (r_marker == apfp_pkg::EXT_MARKER);
        n_header   = r_header;
        n_marker   = r_marker;
        n_ext_high = r_ext_high;
        n_decl     = r_decl;
        start      = L_SHORT_HDR;
        pay_end    = '0;
        is_pay     = 1'b0;

        if (p < L_HDR) begin
            case (p[1:0])
                2'd0:    n_header[31:24] = b;
                2'd1:    n_header[23:16] = b;
                2'd2:    n_header[15:8]  = b;
                default: n_header[7:0]   = b;
            endcase
        end else if (p == L_HDR) begin
            // marker byte doubles as short Lc; zero selects extended form
            n_marker = b;
            n_decl   = {8'h00, b};
        end else if (ext_cur && p == L_SHORT_HDR) begin
            n_ext_high = b;
        end else if (ext_cur && p == L_SHORT_LE) begin
            n_decl = {r_ext_high, b};
        end else begin
            start   = ext_cur ? L_EXT_HDR : L_SHORT_HDR;
            pay_end = start + {2'b00, r_decl};
            is_pay  = (p >= start) && (p < pay_end);
        end

        // past the size limit the payload is dropped
        emit_pay = is_pay && (total <= {1'b0, r_max_frame});
    end

    // verdict, from the state as updated by this byte
    always_comb begin
        ext_v = (n_marker == apfp_pkg::EXT_MARKER);
        len_v = {2'b00, n_decl};
        if (total < L_HDR || total > {1'b0, r_max_frame}) begin
            status = apfp_pkg::STATUS_RANGE;
        end else if (total == L_HDR) begin
            status = apfp_pkg::STATUS_OK;
        end else if (!ext_v) begin
            status = (total == len_v + L_SHORT_HDR || total == len_v + L_SHORT_LE)
                   ? apfp_pkg::STATUS_OK : apfp_pkg::STATUS_MISMATCH;
        end else if (total < L_EXT_HDR) begin
            status = apfp_pkg::STATUS_MISMATCH;
        end else begin
            status = (total == len_v + L_EXT_HDR || total == len_v + L_EXT_LE)
                   ? apfp_pkg::STATUS_OK : apfp_pkg::STATUS_MISMATCH;
        end
    end

    // result items
    always_comb begin
        pay_item               = '0;
        pay_item.result_kind   = apfp_pkg::KIND_PAYLOAD;
        pay_item.payload_byte  = b;
        pay_item.payload_index = 16'(p - start);
        pay_item.run_last      = !last;

        verdict_item                  = '0;
        verdict_item.result_kind      = apfp_pkg::KIND_VERDICT;
        verdict_item.class_byte       = n_header[31:24];
        verdict_item.instruction_byte = n_header[23:16];
        verdict_item.param_one        = n_header[15:8];
        verdict_item.param_two        = n_header[7:0];
        verdict_item.payload_length   = n_decl;
        verdict_item.frame_status     = status;
        verdict_item.run_last         = 1'b1;

        // payload first when both come from one byte
        push.cnt   = in_acc ? (2'(emit_pay) + 2'(last)) : 2'd0;
        push.slot0 = emit_pay ? pay_item : verdict_item;
        push.slot1 = verdict_item;
    end

    // saturating position count; the final byte returns all frame state to zero
    always_comb begin
        n_byte_count = (r_byte_count != apfp_pkg::COUNT_MAX)
                     ? r_byte_count + 17'd1 : r_byte_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame  <= apfp_pkg::MAX_FRAME_RST;
            r_byte_count <= '0;
            r_header     <= '0;
            r_marker     <= '0;
            r_ext_high   <= '0;
            r_decl       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_frame <= i_cfg_data;
            end
            if (in_acc) begin
                if (last) begin
                    r_byte_count <= '0;
                    r_header     <= '0;
                    r_marker     <= '0;
                    r_ext_high   <= '0;
                    r_decl       <= '0;
                end else begin
                    r_byte_count <= n_byte_count;
                    r_header     <= n_header;
                    r_marker     <= n_marker;
                    r_ext_high   <= n_ext_high;
                    r_decl       <= n_decl;
                end
            end
        end
    end

    // result register / queue; parts input side from output stall
    apfp_out_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_room_two (room_two),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last) |=> (r_byte_count == '0 && r_header == '0 && r_decl == '0))
        else $error("frame state not cleared after final byte");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !last && r_byte_count == apfp_pkg::COUNT_MAX)
            |=> (r_byte_count == apfp_pkg::COUNT_MAX))
        else $error("byte count wrapped");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !last && r_byte_count != apfp_pkg::COUNT_MAX)
            |=> (r_byte_count == $past(r_byte_count) + 17'd1))
        else $error("byte count did not advance");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef logic [7:0] t_byte_q [$];

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    apfp_pkg::t_in_item   i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    apfp_pkg::t_out_item  o_out_data;
    logic                 i_cfg_we;
    logic [16:0]          i_cfg_data;

    apdu_frame_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    int                   fail_count;
    int unsigned          in_gap_pct;      // chance of an input gap after a transaction
    int unsigned          out_stall_pct;   // chance of starting an output stall burst
    int unsigned          out_stall_left;
    t_byte_q              frame_q;         // frame under construction
    apfp_pkg::t_out_item  parser_results_q [$];

    // Parser shadow state: mirrors the frame tracking of the block
    logic [16:0] frame_limit;     // max_frame_bytes
    logic [16:0] frame_pos;       // saturating byte counter
    logic [31:0] hdr_word;        // CLA INS P1 P2, CLA on top
    logic [7:0]  lc_marker;       // byte 4 as received
    logic [7:0]  lc_high;         // high byte of extended Lc
    logic [15:0] lc_value;        // decoded Lc

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A correct run ends long before this timeout.
    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------
    function automatic void clear_frame_state();
        frame_pos = '0;
        hdr_word  = '0;
        lc_marker = '0;
        lc_high   = '0;
        lc_value  = '0;
    endfunction

    // Verdict for a frame of 'total' bytes. Range check wins over everything.
    function automatic logic [1:0] frame_verdict(input int total);
        logic ext;
        int   lc;
        ext = (lc_marker == apfp_pkg::EXT_MARKER);
        lc  = int'(lc_value);
        if (total < apfp_pkg::HDR_LEN || total > int'(frame_limit))
            return apfp_pkg::STATUS_RANGE;
        if (total == apfp_pkg::HDR_LEN)
            return apfp_pkg::STATUS_OK;
        if (!ext)
            return (total == apfp_pkg::SHORT_HDR + lc || total == apfp_pkg::SHORT_LE + lc) ?
                   apfp_pkg::STATUS_OK : apfp_pkg::STATUS_MISMATCH;
        if (total < apfp_pkg::EXT_HDR)
            return apfp_pkg::STATUS_MISMATCH;
        return (total == apfp_pkg::EXT_HDR + lc || total == apfp_pkg::EXT_LE + lc) ?
               apfp_pkg::STATUS_OK : apfp_pkg::STATUS_MISMATCH;
    endfunction

    // Advance the shadow parser by one accepted byte and queue what it yields.
    function automatic void parse_frame_byte(input logic [7:0] b, input logic fe);
        int                   pos;
        int                   start;
        int                   total;
        logic                 ext;
        logic                 in_payload;
        apfp_pkg::t_out_item  res;
        pos        = int'(frame_pos);
        start      = 0;
        in_payload = 1'b0;
        if (pos < apfp_pkg::HDR_LEN) begin
            hdr_word[8*(3-pos) +: 8] = b;
        end else if (pos == apfp_pkg::HDR_LEN) begin
            lc_marker = b;
            lc_value  = (b != apfp_pkg::EXT_MARKER) ? 16'(b) : 16'd0;
        end else begin
            ext = (lc_marker == apfp_pkg::EXT_MARKER);
            if (ext && pos == apfp_pkg::SHORT_HDR) begin
                lc_high = b;
            end else if (ext && pos == apfp_pkg::SHORT_LE) begin
                lc_value = {lc_high, b};
            end else begin
                start = ext ? apfp_pkg::EXT_HDR : apfp_pkg::SHORT_HDR;
                if (pos >= start && pos < start + int'(lc_value))
                    in_payload = 1'b1;
            end
        end

        if (frame_pos < apfp_pkg::COUNT_MAX)
            frame_pos = frame_pos + 17'd1;
        total = pos + 1;

        // payload bytes past the size limit are dropped
        if (in_payload && total <= int'(frame_limit)) begin
            res               = '0;
            res.result_kind   = apfp_pkg::KIND_PAYLOAD;
            res.payload_byte  = b;
            res.payload_index = 16'(pos - start);
            res.run_last      = !fe;
            parser_results_q.push_back(res);
        end

        if (fe) begin
            res                  = '0;
            res.result_kind      = apfp_pkg::KIND_VERDICT;
            res.class_byte       = hdr_word[31:24];
            res.instruction_byte = hdr_word[23:16];
            res.param_one        = hdr_word[15:8];
            res.param_two        = hdr_word[7:0];
            res.payload_length   = lc_value;
            res.frame_status     = frame_verdict(total);
            res.run_last         = 1'b1;
            parser_results_q.push_back(res);
            clear_frame_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking and output stall generation
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(input apfp_pkg::t_out_item got);
        apfp_pkg::t_out_item want;
        if (parser_results_q.size() == 0) begin
            $error("result_kind: expected no result, actual %0h", got.result_kind);
            fail_count++;
            return;
        end
        want = parser_results_q.pop_front();
        check_field("result_kind",      want.result_kind,      got.result_kind);
        check_field("payload_byte",     want.payload_byte,     got.payload_byte);
        check_field("payload_index",    want.payload_index,    got.payload_index);
        check_field("class_byte",       want.class_byte,       got.class_byte);
        check_field("instruction_byte", want.instruction_byte, got.instruction_byte);
        check_field("param_one",        want.param_one,        got.param_one);
        check_field("param_two",        want.param_two,        got.param_two);
        check_field("payload_length",   want.payload_length,   got.payload_length);
        check_field("frame_status",     want.frame_status,     got.frame_status);
        check_field("run_last",         want.run_last,         got.run_last);
    endfunction

    // Mostly short idles, now and then a long one.
    function automatic int unsigned pick_idle_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    // Values are sampled at the edge before any of this step's updates land,
    // then the next stall value is scheduled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result(o_out_data);
        if (out_stall_left > 0) begin
            out_stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(99) < out_stall_pct) begin
            out_stall_left = pick_idle_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus primitives
    // ------------------------------------------------------------------
    // One input transaction. Valid stays high into the next call when no gap
    // is drawn, so back-to-back bytes need no extra assignment.
    task automatic send_byte(input logic [7:0] b, input logic fe);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_data  <= '{frame_byte: b, frame_end: fe};
        do @(posedge i_clk); while (o_in_stall);
        parse_frame_byte(b, fe);
        gap = ($urandom_range(99) < in_gap_pct) ? pick_idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Let everything in flight come out, then idle on for bytes that
    // produce nothing.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (parser_results_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_frame_limit(input logic [16:0] limit);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_limit = limit;
    endtask

    function automatic int unsigned pick_lc();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 85) return $urandom_range(16);
        if (r < 97) return $urandom_range(300);
        return $urandom_range(1200);
    endfunction

    // Mostly well-formed frames with random content; some are cut short or
    // padded, and a few are pure noise.
    task automatic build_random_frame();
        int unsigned form;
        int unsigned lc;
        int unsigned n;
        frame_q.delete();
        if ($urandom_range(99) < 8) begin
            n = $urandom_range(12, 1);
            repeat (n) frame_q.push_back(8'($urandom));
            return;
        end
        repeat (4) frame_q.push_back(8'($urandom));
        form = $urandom_range(9);
        lc   = pick_lc();
        if (form >= 1 && form < 5) begin
            // short form: Lc 1..255, optional one-byte Le
            if (lc == 0) lc = 1;
            if (lc > 255) lc = 255;
            frame_q.push_back(8'(lc));
            repeat (lc) frame_q.push_back(8'($urandom));
            if ($urandom_range(1)) frame_q.push_back(8'($urandom));
        end else if (form >= 5) begin
            // extended form, optional two-byte Le
            frame_q.push_back(apfp_pkg::EXT_MARKER);
            frame_q.push_back(8'(lc >> 8));
            frame_q.push_back(8'(lc));
            repeat (lc) frame_q.push_back(8'($urandom));
            if ($urandom_range(1)) repeat (2) frame_q.push_back(8'($urandom));
        end
        n = $urandom_range(99);
        if (n < 10) begin
            n = $urandom_range(3, 1);
            if (n > frame_q.size() - 1) n = frame_q.size() - 1;
            repeat (n) void'(frame_q.pop_back());
        end else if (n < 20) begin
            repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Header-only and too-short frames at the reset limit.
    task automatic test_header_frames();
        frame_q = '{8'hFF, 8'h00, 8'hFF, 8'h00};
        send_frame();
        frame_q = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        send_frame();
        // too short: missing header bytes read back as zero
        frame_q = '{8'hA5};
        send_frame();
    endtask

    // Short form: payload on the final byte, then an Lc of 255 with only two bytes after it.
    task automatic test_short_form();
        frame_q = '{8'h00, 8'hFF, 8'h12, 8'h34, 8'h01, 8'hFF};
        send_frame();
        frame_q = '{8'h80, 8'hCA, 8'h5A, 8'hC3, 8'hFF, 8'h11, 8'h22};
        send_frame();
    endtask

    // Extended form with Lc 0 and with Lc 1 plus a two-byte Le.
    task automatic test_extended_form();
        frame_q = '{8'h01, 8'h02, 8'h03, 8'h04, apfp_pkg::EXT_MARKER, 8'h00, 8'h00};
        send_frame();
        frame_q = '{8'hFE, 8'h7F, 8'h80, 8'h01, apfp_pkg::EXT_MARKER, 8'h00, 8'h01,
                    8'hAB, 8'h00, 8'h00};
        send_frame();
    endtask

    // Payload that runs past a small limit is cut off; the verdict is too long.
    task automatic test_size_limit();
        set_frame_limit(17'd10);
        frame_q = '{8'h10, 8'h20, 8'h30, 8'h40, 8'd20};
        repeat (20) frame_q.push_back(8'($urandom));
        send_frame();
        set_frame_limit(17'd4);
        frame_q = '{8'h11, 8'h22, 8'h33, 8'h44};
        send_frame();
        frame_q = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h01, 8'h99};
        send_frame();
    endtask

    // Limits below the header size: every frame is out of range.
    task automatic test_limit_below_header();
        set_frame_limit(17'd3);
        frame_q = '{8'hC0, 8'hDE, 8'h00, 8'h01, 8'h02, 8'hAA, 8'hBB};
        send_frame();
        set_frame_limit(17'd0);
        frame_q = '{8'hC0, 8'hDE, 8'h00, 8'h01};
        send_frame();
    endtask

    // Random frames across several limits and idle profiles.
    task automatic test_random_frames();
        logic [16:0] limits [4];
        int unsigned gap_pcts [4];
        int unsigned stall_pcts [4];
        int unsigned sent;
        limits     = '{17'd1024, 17'd4, 17'd5, 17'd65545};
        gap_pcts   = '{30, 0, 50, 10};
        stall_pcts = '{30, 0, 10, 60};
        limits[2]  = 17'($urandom_range(400, 5));
        for (int ph = 0; ph < 4; ph++) begin
            set_frame_limit(limits[ph]);
            in_gap_pct    = gap_pcts[ph];
            out_stall_pct = stall_pcts[ph];
            sent = 0;
            while (sent < 240) begin
                build_random_frame();
                sent += frame_q.size();
                send_frame();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        fail_count     = 0;
        in_gap_pct     = 25;
        out_stall_pct  = 25;
        out_stall_left = 0;
        frame_limit    = apfp_pkg::MAX_FRAME_RST;
        clear_frame_state();

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_frames();
        test_short_form();
        test_extended_form();
        test_size_limit();
        test_limit_below_header();
        test_random_frames();
        drain();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
